@@ src/qas_pkg.sv @@
package qas_pkg;

    // Upper bound on argument slots; the count field is 8 bits wide, so the
    // effective limit never goes past 256.
    localparam int MAX_SLOTS = 256;
    localparam int SLOT_CAP  = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
    localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_CAP);

    localparam logic [8:0] ARG_SLOTS_RESET   = 9'd64;
    localparam logic       KEEP_QUOTES_RESET = 1'b0;

    localparam logic [1:0] CFG_ARG_SLOTS   = 2'd0;
    localparam logic [1:0] CFG_KEEP_QUOTES = 2'd1;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    localparam int RESULTS_MAX = 3;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_ARG_END  = 2'd1,
        KIND_LINE_END = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_DOUBLE = 2'd1,
        QUOTE_SINGLE = 2'd2
    } quote_t;

    typedef struct packed {
        logic       in_argument;
        quote_t     open_quote;
        logic       escape_pending;
        logic       discarding;
        logic [7:0] argument_count;
    } line_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [7:0] arg_index;
        logic       overflow;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        result_t [RESULTS_MAX-1:0] res;
        logic [1:0]                cnt;
    } bundle_t;

endpackage

@@ src/quoted_argument_splitter_core.sv @@
// Splits a byte stream of command lines into arguments, one input byte per
// cycle while the queue has room. Each byte passes an input register, then a
// combinational decode that updates the line state and yields zero to three
// output words, which drain from a small result queue one per cycle while the
// receiver is ready. Bytes that give at most one word keep a sustained rate of
// one byte per clock while the receiver is ready; a byte that gives two or three
// words (an escape inside quotes, or a line end that closes an argument) holds
// the input until the queue is down to its last word and that word leaves.
// A byte passes the input register and then the result queue before its first
// word shows. Configuration writes (index 0 argument slots, index 1 keep-quotes)
// are always taken and must be made only while no byte is in flight.
module quoted_argument_splitter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [7:0] arg_index,
    output logic       overflow,
    output logic       last_of_run
);

    logic [8:0]           arg_slots_reg;
    logic                 keep_quotes_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    qas_pkg::line_state_t state_reg;
    qas_pkg::line_state_t state_next;
    qas_pkg::bundle_t     bundle;
    qas_pkg::result_t     head;
    logic                 queue_free;
    logic                 fire;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && queue_free;
    assign in_ready  = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_slots_reg   <= qas_pkg::ARG_SLOTS_RESET;
            keep_quotes_reg <= qas_pkg::KEEP_QUOTES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qas_pkg::CFG_ARG_SLOTS:   arg_slots_reg   <= cfg_data;
                qas_pkg::CFG_KEEP_QUOTES: keep_quotes_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    qas_decode u_decode (
        .in_byte     (in_byte_reg),
        .cur         (state_reg),
        .arg_slots   (arg_slots_reg),
        .keep_quotes (keep_quotes_reg),
        .nxt         (state_next),
        .bundle      (bundle)
    );

    qas_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .load_bundle (bundle),
        .out_ready   (out_ready),
        .free        (queue_free),
        .out_valid   (out_valid),
        .head        (head)
    );

    assign kind        = head.kind;
    assign out_byte    = head.out_byte;
    assign arg_index   = head.arg_index;
    assign overflow    = head.overflow;
    assign last_of_run = head.last_of_run;

    a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == qas_pkg::KIND_LINE_END |-> last_of_run)
        else $error("line end is not the last word of its byte");

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_byte_reg == qas_pkg::CHAR_NUL |=> state_reg == '0)
        else $error("line state not cleared after line end");

    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte lost or changed");

    a_no_overflow_on_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != qas_pkg::KIND_LINE_END |-> !overflow)
        else $error("overflow flag outside a line end");

endmodule

@@ src/qas_decode.sv @@
module qas_decode (
    input  logic [7:0]           in_byte,
    input  qas_pkg::line_state_t cur,
    input  logic [8:0]           arg_slots,
    input  logic                 keep_quotes,
    output qas_pkg::line_state_t nxt,
    output qas_pkg::bundle_t     bundle
);

    function automatic qas_pkg::result_t mk_result(
        input qas_pkg::kind_t kind,
        input logic [7:0]     data,
        input logic [7:0]     idx,
        input logic           ovf
    );
        qas_pkg::result_t r;
        r.kind        = kind;
        r.out_byte    = data;
        r.arg_index   = idx;
        r.overflow    = ovf;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    logic [8:0] slots;
    logic       is_blank;
    logic       at_limit;

    assign slots    = (arg_slots > qas_pkg::SLOT_LIMIT) ? qas_pkg::SLOT_LIMIT : arg_slots;
    assign is_blank = (in_byte == qas_pkg::CHAR_SPACE) || (in_byte == qas_pkg::CHAR_TAB);
    // No new argument once count + 1 reaches the slot count (covers zero slots too).
    assign at_limit = ({1'b0, cur.argument_count} + 9'd1) >= slots;

    always_comb
    begin
        qas_pkg::result_t [qas_pkg::RESULTS_MAX-1:0] res;
        logic [1:0]  cnt;
        logic        do_arg;
        logic [7:0]  close_char;
        res        = '0;
        cnt        = 2'd0;
        do_arg     = 1'b0;
        nxt        = cur;
        close_char = (cur.open_quote == qas_pkg::QUOTE_DOUBLE) ? qas_pkg::CHAR_DQUOTE
                                                               : qas_pkg::CHAR_SQUOTE;

        if (in_byte == qas_pkg::CHAR_NUL)
        begin
            if (!cur.discarding && cur.in_argument)
            begin
                // A backslash left dangling at line end comes out as a literal byte.
                if (cur.escape_pending)
                begin
                    res[cnt] = mk_result(qas_pkg::KIND_BYTE, qas_pkg::CHAR_BACKSLASH,
                                         cur.argument_count, 1'b0);
                    cnt = cnt + 2'd1;
                end
                res[cnt] = mk_result(qas_pkg::KIND_ARG_END, 8'd0, cur.argument_count, 1'b0);
                cnt = cnt + 2'd1;
                nxt.argument_count = cur.argument_count + 8'd1;
            end
            res[cnt] = mk_result(qas_pkg::KIND_LINE_END, 8'd0, nxt.argument_count,
                                 cur.discarding);
            cnt = cnt + 2'd1;
            nxt = '0;
        end
        else if (cur.discarding)
        begin
            nxt = cur;
        end
        else if (!cur.in_argument)
        begin
            if (!is_blank)
            begin
                if (at_limit)
                begin
                    nxt.discarding = 1'b1;
                end
                else
                begin
                    nxt.in_argument = 1'b1;
                    do_arg = 1'b1;
                end
            end
        end
        else
        begin
            do_arg = 1'b1;
        end

        if (do_arg)
        begin
            if (cur.escape_pending)
            begin
                nxt.escape_pending = 1'b0;
                if (cur.open_quote != qas_pkg::QUOTE_NONE &&
                    !(in_byte == close_char && !keep_quotes))
                begin
                    res[cnt] = mk_result(qas_pkg::KIND_BYTE, qas_pkg::CHAR_BACKSLASH,
                                         cur.argument_count, 1'b0);
                    cnt = cnt + 2'd1;
                end
                res[cnt] = mk_result(qas_pkg::KIND_BYTE, in_byte, cur.argument_count, 1'b0);
                cnt = cnt + 2'd1;
            end
            else if (cur.open_quote != qas_pkg::QUOTE_NONE)
            begin
                if (in_byte == close_char)
                begin
                    nxt.open_quote = qas_pkg::QUOTE_NONE;
                    if (keep_quotes)
                    begin
                        res[cnt] = mk_result(qas_pkg::KIND_BYTE, in_byte,
                                             cur.argument_count, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                end
                else if (in_byte == qas_pkg::CHAR_BACKSLASH)
                begin
                    nxt.escape_pending = 1'b1;
                end
                else
                begin
                    res[cnt] = mk_result(qas_pkg::KIND_BYTE, in_byte, cur.argument_count, 1'b0);
                    cnt = cnt + 2'd1;
                end
            end
            else if (in_byte == qas_pkg::CHAR_DQUOTE || in_byte == qas_pkg::CHAR_SQUOTE)
            begin
                if (keep_quotes)
                begin
                    res[cnt] = mk_result(qas_pkg::KIND_BYTE, in_byte, cur.argument_count, 1'b0);
                    cnt = cnt + 2'd1;
                end
                nxt.open_quote = (in_byte == qas_pkg::CHAR_DQUOTE) ? qas_pkg::QUOTE_DOUBLE
                                                                   : qas_pkg::QUOTE_SINGLE;
            end
            else if (in_byte == qas_pkg::CHAR_BACKSLASH && !keep_quotes)
            begin
                nxt.escape_pending = 1'b1;
            end
            else if (is_blank)
            begin
                res[cnt] = mk_result(qas_pkg::KIND_ARG_END, 8'd0, cur.argument_count, 1'b0);
                cnt = cnt + 2'd1;
                nxt.argument_count = cur.argument_count + 8'd1;
                nxt.in_argument    = 1'b0;
            end
            else
            begin
                res[cnt] = mk_result(qas_pkg::KIND_BYTE, in_byte, cur.argument_count, 1'b0);
                cnt = cnt + 2'd1;
            end
        end

        if (cnt != 2'd0)
        begin
            res[cnt - 2'd1].last_of_run = 1'b1;
        end

        bundle.res = res;
        bundle.cnt = cnt;
    end

endmodule

@@ src/qas_result_queue.sv @@
module qas_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  qas_pkg::bundle_t  load_bundle,
    input  logic              out_ready,
    output logic              free,
    output logic              out_valid,
    output qas_pkg::result_t  head
);

    qas_pkg::result_t [qas_pkg::RESULTS_MAX-1:0] slot_reg;
    qas_pkg::result_t [qas_pkg::RESULTS_MAX-1:0] slot_next;
    logic [1:0] rem_reg;
    logic [1:0] rem_next;
    logic       take;

    assign out_valid = (rem_reg != 2'd0);
    assign head      = slot_reg[0];
    assign take      = out_valid && out_ready;
    // A new set of words may come in once at most the last one is still held
    // and it leaves this cycle.
    assign free      = (rem_reg == 2'd0) || (rem_reg == 2'd1 && out_ready);

    always_comb
    begin
        slot_next = slot_reg;
        rem_next  = rem_reg;
        if (load)
        begin
            slot_next = load_bundle.res;
            rem_next  = load_bundle.cnt;
        end
        else if (take)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            rem_next     = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    a_last_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head.last_of_run |-> rem_reg >= 2'd2)
        else $error("word not marked last but nothing follows it");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> rem_reg == 2'd0 || (rem_reg == 2'd1 && take))
        else $error("new words loaded over pending ones");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import qas_pkg::*;

    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 46;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_CAP     = 40;
    localparam int SCRIPT_ROWS   = 30;

    typedef struct {
        logic       is_cfg;
        logic [1:0] reg_index;
        logic [8:0] reg_data;
        logic [7:0] char_in;
        logic       pinned;
        result_t    word;
    } script_row_t;

    // A pinned word replaces the last word predicted for its input byte.
    typedef struct {
        logic    pinned;
        result_t word;
    } pin_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_ARG_SLOTS;
    logic [8:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = CHAR_NUL;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] arg_index;
    logic       overflow;
    logic       last_of_run;

    // Predictor copy of the configuration and the line state.
    logic [8:0] slots_reg = ARG_SLOTS_RESET;
    logic       keep_reg = KEEP_QUOTES_RESET;
    logic       line_in_arg = 1'b0;
    quote_t     line_quote = QUOTE_NONE;
    logic       line_esc = 1'b0;
    logic       line_drop = 1'b0;
    logic [7:0] line_count = 8'd0;

    result_t     expected_words[$];
    result_t     byte_words[$];
    pin_t        pins[$];
    pin_t        no_pin;
    pin_t        next_pin;
    result_t     want;
    script_row_t script [SCRIPT_ROWS];

    int mismatches = 0;
    int cycles = 0;
    int sent_bytes = 0;
    bit calm = 1'b0;

    quoted_argument_splitter_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quoted_argument_splitter_core verification failed");
            $finish;
        end
    end

    task automatic report(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] exp);
        if (got !== exp)
            report($sformatf("%s got %0h expected %0h", name, got, exp));
    endtask

    function automatic logic is_blank(logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB;
    endfunction

    function automatic logic [7:0] closer(quote_t q);
        return (q == QUOTE_DOUBLE) ? CHAR_DQUOTE : CHAR_SQUOTE;
    endfunction

    function automatic void add_word(kind_t k, logic [7:0] b, logic ovf);
        result_t w;
        w.kind        = k;
        w.out_byte    = b;
        w.arg_index   = line_count;
        w.overflow    = ovf;
        w.last_of_run = 1'b0;
        byte_words.push_back(w);
    endfunction

    // One byte of an argument that is already open.
    function automatic void argument_char(logic [7:0] c);
        if (line_esc)
        begin
            line_esc = 1'b0;
            if (line_quote != QUOTE_NONE && !(c == closer(line_quote) && !keep_reg))
                add_word(KIND_BYTE, CHAR_BACKSLASH, 1'b0);
            add_word(KIND_BYTE, c, 1'b0);
        end
        else if (line_quote != QUOTE_NONE)
        begin
            if (c == closer(line_quote))
            begin
                line_quote = QUOTE_NONE;
                if (keep_reg)
                    add_word(KIND_BYTE, c, 1'b0);
            end
            else if (c == CHAR_BACKSLASH)
                line_esc = 1'b1;
            else
                add_word(KIND_BYTE, c, 1'b0);
        end
        else if (c == CHAR_DQUOTE || c == CHAR_SQUOTE)
        begin
            if (keep_reg)
                add_word(KIND_BYTE, c, 1'b0);
            line_quote = (c == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
        end
        else if (c == CHAR_BACKSLASH && !keep_reg)
            line_esc = 1'b1;
        else if (is_blank(c))
        begin
            add_word(KIND_ARG_END, CHAR_NUL, 1'b0);
            line_count  = line_count + 8'd1;
            line_in_arg = 1'b0;
        end
        else
            add_word(KIND_BYTE, c, 1'b0);
    endfunction

    task automatic split_byte(input logic [7:0] c, input pin_t pin);
        int      lim;
        result_t last;
        byte_words.delete();
        lim = (slots_reg > SLOT_LIMIT) ? int'(SLOT_LIMIT) : int'(slots_reg);
        if (c == CHAR_NUL)
        begin
            if (!line_drop && line_in_arg)
            begin
                if (line_esc)
                    add_word(KIND_BYTE, CHAR_BACKSLASH, 1'b0);
                add_word(KIND_ARG_END, CHAR_NUL, 1'b0);
                line_count = line_count + 8'd1;
            end
            add_word(KIND_LINE_END, CHAR_NUL, line_drop);
            line_in_arg = 1'b0;
            line_quote  = QUOTE_NONE;
            line_esc    = 1'b0;
            line_drop   = 1'b0;
            line_count  = 8'd0;
        end
        else if (!line_drop && !line_in_arg)
        begin
            if (!is_blank(c))
            begin
                if (lim == 0 || int'(line_count) >= lim - 1)
                    line_drop = 1'b1;
                else
                begin
                    line_in_arg = 1'b1;
                    argument_char(c);
                end
            end
        end
        else if (!line_drop)
            argument_char(c);

        if (byte_words.size() != 0)
        begin
            last = byte_words.pop_back();
            last.last_of_run = 1'b1;
            if (pin.pinned)
                last = pin.word;
            byte_words.push_back(last);
        end
        else if (pin.pinned)
            report($sformatf("byte %h predicted no word but one was pinned", c));
        foreach (byte_words[i])
            expected_words.push_back(byte_words[i]);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ARG_SLOTS:   slots_reg = cfg_data;
                    CFG_KEEP_QUOTES: keep_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                next_pin = pins.pop_front();
                split_byte(in_byte, next_pin);
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report($sformatf("unexpected word kind %0d byte %h", kind, out_byte));
                else
                begin
                    want = expected_words.pop_front();
                    check_field("kind", 9'(kind), 9'(want.kind));
                    check_field("out_byte", 9'(out_byte), 9'(want.out_byte));
                    check_field("arg_index", 9'(arg_index), 9'(want.arg_index));
                    check_field("overflow", 9'(overflow), 9'(want.overflow));
                    check_field("last_of_run", 9'(last_of_run), 9'(want.last_of_run));
                end
            end
        end
    end

    // Receiver: ready drops in random bursts, none during the final phase.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Valid stays high across back-to-back bytes; this task only drops it for a gap.
    task automatic send_byte(input logic [7:0] c, input pin_t pin);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pins.push_back(pin);
        in_valid <= 1'b1;
        in_byte  <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_bytes++;
    endtask

    // Register writes wait until every word in flight has drained.
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_blank(c) || c == CHAR_DQUOTE || c == CHAR_SQUOTE || c == CHAR_BACKSLASH);
        return c;
    endfunction

    task automatic send_quoted(input logic [7:0] q);
        send_byte(q, no_pin);
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 5))
                0: send_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, no_pin);
                1: send_byte((q == CHAR_DQUOTE) ? CHAR_SQUOTE : CHAR_DQUOTE, no_pin);
                2:
                begin
                    send_byte(CHAR_BACKSLASH, no_pin);
                    send_byte($urandom_range(0, 1) ? q : 8'($urandom_range(1, 255)), no_pin);
                end
                default: send_byte(plain_byte(), no_pin);
            endcase
        end
        // Now and then the quote is left open until the line ends.
        if ($urandom_range(0, 9) != 0)
            send_byte(q, no_pin);
    endtask

    function automatic script_row_t byte_row(logic [7:0] c);
        script_row_t r;
        r.is_cfg    = 1'b0;
        r.reg_index = CFG_ARG_SLOTS;
        r.reg_data  = '0;
        r.char_in   = c;
        r.pinned    = 1'b0;
        r.word      = '0;
        return r;
    endfunction

    function automatic script_row_t pinned_row(logic [7:0] c, kind_t k, logic [7:0] b,
                                               logic [7:0] idx, logic ovf);
        script_row_t r;
        r = byte_row(c);
        r.pinned           = 1'b1;
        r.word.kind        = k;
        r.word.out_byte    = b;
        r.word.arg_index   = idx;
        r.word.overflow    = ovf;
        r.word.last_of_run = 1'b1;
        return r;
    endfunction

    function automatic script_row_t cfg_row(logic [1:0] idx, logic [8:0] data);
        script_row_t r;
        r = byte_row(CHAR_NUL);
        r.is_cfg    = 1'b1;
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    initial
    begin
        pin_t       pin;
        logic [8:0] slots;
        logic       keep;
        int         start_count;

        no_pin.pinned = 1'b0;
        no_pin.word   = '0;

        script = '{
            // Reset settings: 64 slots, quotes stripped.
            pinned_row(CHAR_NUL, KIND_LINE_END, CHAR_NUL, 8'd0, 1'b0),
            pinned_row(8'h41, KIND_BYTE, 8'h41, 8'd0, 1'b0),
            pinned_row(8'hFF, KIND_BYTE, 8'hFF, 8'd0, 1'b0),
            pinned_row(CHAR_TAB, KIND_ARG_END, CHAR_NUL, 8'd0, 1'b0),
            byte_row(CHAR_SPACE),
            byte_row(CHAR_DQUOTE),
            byte_row(CHAR_BACKSLASH),
            // Escaped closing quote inside quotes comes out alone.
            pinned_row(CHAR_DQUOTE, KIND_BYTE, CHAR_DQUOTE, 8'd1, 1'b0),
            byte_row(CHAR_BACKSLASH),
            byte_row(8'h41),
            byte_row(CHAR_SQUOTE),
            byte_row(CHAR_BACKSLASH),
            // Line end with an open quote and a dangling backslash.
            byte_row(CHAR_NUL),
            byte_row(CHAR_BACKSLASH),
            pinned_row(CHAR_SPACE, KIND_BYTE, CHAR_SPACE, 8'd0, 1'b0),
            byte_row(CHAR_NUL),
            cfg_row(CFG_ARG_SLOTS, 9'd2),
            cfg_row(CFG_KEEP_QUOTES, 9'd1),
            pinned_row(CHAR_DQUOTE, KIND_BYTE, CHAR_DQUOTE, 8'd0, 1'b0),
            byte_row(CHAR_BACKSLASH),
            byte_row(CHAR_DQUOTE),
            pinned_row(CHAR_DQUOTE, KIND_BYTE, CHAR_DQUOTE, 8'd0, 1'b0),
            pinned_row(CHAR_BACKSLASH, KIND_BYTE, CHAR_BACKSLASH, 8'd0, 1'b0),
            pinned_row(CHAR_SPACE, KIND_ARG_END, CHAR_NUL, 8'd0, 1'b0),
            byte_row(8'h62),
            pinned_row(CHAR_NUL, KIND_LINE_END, CHAR_NUL, 8'd1, 1'b1),
            // A single slot leaves no room for any argument.
            cfg_row(CFG_ARG_SLOTS, 9'd1),
            byte_row(CHAR_SPACE),
            byte_row(8'h78),
            pinned_row(CHAR_NUL, KIND_LINE_END, CHAR_NUL, 8'd0, 1'b1)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_reg(script[i].reg_index, script[i].reg_data);
            else
            begin
                pin.pinned = script[i].pinned;
                pin.word   = script[i].word;
                send_byte(script[i].char_in, pin);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == PHASES - 1);
            case (p)
                0: begin slots = 9'd256; keep = 1'b1; end
                1: begin slots = 9'd0;   keep = 1'b0; end
                2: begin slots = 9'd3;   keep = 1'b1; end
                3: begin slots = 9'd511; keep = 1'b0; end
                4: begin slots = 9'($urandom_range(1, 6));   keep = 1'($urandom_range(0, 1)); end
                default: begin slots = 9'($urandom_range(0, 511)); keep = 1'($urandom_range(0, 1)); end
            endcase
            write_reg(CFG_ARG_SLOTS, slots);
            write_reg(CFG_KEEP_QUOTES, {8'd0, keep});

            start_count = sent_bytes;
            while (sent_bytes - start_count < PHASE_BYTES)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    repeat ($urandom_range(1, 12))
                        send_byte(8'($urandom_range(1, 255)), no_pin);
                end
                else
                begin
                    repeat ($urandom_range(0, 5))
                    begin
                        repeat ($urandom_range(0, 2))
                            send_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, no_pin);
                        repeat ($urandom_range(1, 3))
                        begin
                            case ($urandom_range(0, 3))
                                0: repeat ($urandom_range(1, 3)) send_byte(plain_byte(), no_pin);
                                1: send_quoted(CHAR_DQUOTE);
                                2: send_quoted(CHAR_SQUOTE);
                                default:
                                begin
                                    send_byte(CHAR_BACKSLASH, no_pin);
                                    send_byte(8'($urandom_range(1, 255)), no_pin);
                                end
                            endcase
                        end
                    end
                    if ($urandom_range(0, 9) == 0)
                        send_byte(CHAR_BACKSLASH, no_pin);
                end
                send_byte(CHAR_NUL, no_pin);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("quoted_argument_splitter_core verification clean");
        else
            $display("quoted_argument_splitter_core verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/qas_pkg.sv
src/qas_decode.sv
src/qas_result_queue.sv
src/quoted_argument_splitter_core.sv
test/testbench.sv
